// ===== design/swept_box_collision_time_unit_macros.svh =====
// ----------------------------------------------------------------------------
// swept box collision time assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef SWEPT_BOX_COLLISION_TIME_UNIT_MACROS_SVH
`define SWEPT_BOX_COLLISION_TIME_UNIT_MACROS_SVH

// same-cycle implication
`define SBCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SBCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sbct_pkg.sv =====
// ----------------------------------------------------------------------------
// sbct_pkg
// shared types and constants of the swept box collision time unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbct_pkg;

  localparam int COORD_BITS_DEF     = 16;
  localparam int MOVE_FRAC_BITS_DEF = 6;
  localparam int MOVE_BITS          = 16;
  localparam int TIME_FRAC          = 8;
  localparam int TIME_BITS          = 32;
  localparam int DT_BITS            = 16;
  localparam int FACE_BITS          = 3;

  typedef enum logic [FACE_BITS-1:0] {
    FACE_NONE   = 3'd0,
    FACE_RIGHT  = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_TOP    = 3'd3,
    FACE_BOTTOM = 3'd4
  } face_t;

  typedef struct packed {
    logic               valid;
    logic               zx;
    logic               zy;
    logic               gx_pos;
    logic               gy_pos;
    logic [DT_BITS-1:0] dt;
  } side_t;

endpackage

// ===== design/sbct_front.sv =====
// ----------------------------------------------------------------------------
// sbct_front
// entry and exit gaps per axis, their magnitudes and the move magnitudes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbct_front #(
  parameter int COORD_BITS     = 16,
  parameter int MOVE_FRAC_BITS = 6,
  parameter int NUM_BITS       = 31
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [COORD_BITS-1:0]        obj_left,
  input  logic signed [COORD_BITS-1:0]        obj_top,
  input  logic signed [COORD_BITS-1:0]        obj_right,
  input  logic signed [COORD_BITS-1:0]        obj_bottom,
  input  logic signed [COORD_BITS-1:0]        other_left,
  input  logic signed [COORD_BITS-1:0]        other_top,
  input  logic signed [COORD_BITS-1:0]        other_right,
  input  logic signed [COORD_BITS-1:0]        other_bottom,
  input  logic signed [sbct_pkg::MOVE_BITS-1:0] move_x,
  input  logic signed [sbct_pkg::MOVE_BITS-1:0] move_y,
  input  logic [sbct_pkg::DT_BITS-1:0]        time_limit,
  output sbct_pkg::side_t                     side,
  output logic [NUM_BITS-1:0]                 nx_in,
  output logic [NUM_BITS-1:0]                 nx_out,
  output logic [NUM_BITS-1:0]                 ny_in,
  output logic [NUM_BITS-1:0]                 ny_out,
  output logic                                sx_in,
  output logic                                sx_out,
  output logic                                sy_in,
  output logic                                sy_out,
  output logic [sbct_pkg::MOVE_BITS-1:0]      den_x,
  output logic [sbct_pkg::MOVE_BITS-1:0]      den_y
);
  import sbct_pkg::*;

  localparam int GW = COORD_BITS + 1;
  localparam int SH = MOVE_FRAC_BITS + TIME_FRAC;

  logic signed [GW-1:0] gx_in, gx_out, gy_in, gy_out;
  logic                 mx_pos, my_pos;
  side_t                side_next;

  function automatic logic signed [GW-1:0] sub_ext(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  function automatic logic [NUM_BITS-1:0] scaled_mag(input logic signed [GW-1:0] g);
    logic [GW-1:0] m;
    m = g[GW-1] ? GW'(-g) : GW'(g);
    return {m, {SH{1'b0}}};
  endfunction

  always_comb begin
    mx_pos = !move_x[MOVE_BITS-1] && (move_x != '0);
    my_pos = !move_y[MOVE_BITS-1] && (move_y != '0);
    if (mx_pos) begin
      gx_in  = sub_ext(other_left, obj_right);
      gx_out = sub_ext(other_right, obj_left);
    end else begin
      gx_in  = sub_ext(obj_left, other_right);
      gx_out = sub_ext(obj_right, other_left);
    end
    if (my_pos) begin
      gy_in  = sub_ext(other_top, obj_bottom);
      gy_out = sub_ext(other_bottom, obj_top);
    end else begin
      gy_in  = sub_ext(obj_top, other_bottom);
      gy_out = sub_ext(obj_bottom, other_top);
    end
    side_next.valid  = in_valid;
    side_next.zx     = (move_x == '0);
    side_next.zy     = (move_y == '0);
    side_next.gx_pos = !gx_in[GW-1] && (gx_in != '0);
    side_next.gy_pos = !gy_in[GW-1] && (gy_in != '0);
    side_next.dt     = time_limit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else begin
      side <= side_next;
    end
  end

  always_ff @(posedge clk) begin
    nx_in  <= scaled_mag(gx_in);
    nx_out <= scaled_mag(gx_out);
    ny_in  <= scaled_mag(gy_in);
    ny_out <= scaled_mag(gy_out);
    sx_in  <= gx_in[GW-1];
    sx_out <= gx_out[GW-1];
    sy_in  <= gy_in[GW-1];
    sy_out <= gy_out[GW-1];
    den_x  <= move_x[MOVE_BITS-1] ? MOVE_BITS'(-move_x) : MOVE_BITS'(move_x);
    den_y  <= move_y[MOVE_BITS-1] ? MOVE_BITS'(-move_y) : MOVE_BITS'(move_y);
  end

endmodule

// ===== design/sbct_div.sv =====
// ----------------------------------------------------------------------------
// sbct_div
// pipelined restoring divider, one quotient bit per stage, signed saturation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbct_div #(
  parameter int NUM_BITS = 31
) (
  input  logic                                clk,
  input  logic [NUM_BITS-1:0]                 num,
  input  logic                                neg,
  input  logic [sbct_pkg::MOVE_BITS-1:0]      den,
  output logic signed [sbct_pkg::TIME_BITS-1:0] quot
);
  import sbct_pkg::*;

  localparam int MB = MOVE_BITS;
  localparam int WW = (NUM_BITS > TIME_BITS) ? NUM_BITS + 1 : TIME_BITS + 1;

  logic [MB-1:0]       rem_q [1:NUM_BITS];
  logic [NUM_BITS-1:0] nq_q  [1:NUM_BITS];
  logic [MB-1:0]       den_q [1:NUM_BITS];
  logic                neg_q [1:NUM_BITS];

  for (genvar i = 0; i < NUM_BITS; i++) begin : g_stage
    logic [MB-1:0]       rem_i;
    logic [NUM_BITS-1:0] nq_i;
    logic [MB-1:0]       den_i;
    logic                neg_i;
    logic [MB+1:0]       trial;
    logic [MB:0]         shifted;
    if (i == 0) begin : g_head
      assign rem_i = '0;
      assign nq_i  = num;
      assign den_i = den;
      assign neg_i = neg;
    end else begin : g_tail
      assign rem_i = rem_q[i];
      assign nq_i  = nq_q[i];
      assign den_i = den_q[i];
      assign neg_i = neg_q[i];
    end
    always_comb begin
      shifted = {rem_i, nq_i[NUM_BITS-1]};
      trial   = {1'b0, shifted} - {2'b00, den_i};
    end
    always_ff @(posedge clk) begin
      rem_q[i+1] <= trial[MB+1] ? shifted[MB-1:0] : trial[MB-1:0];
      nq_q[i+1]  <= {nq_i[NUM_BITS-2:0], !trial[MB+1]};
      den_q[i+1] <= den_i;
      neg_q[i+1] <= neg_i;
    end
  end

  logic [WW-1:0] qx;
  assign qx = WW'(nq_q[NUM_BITS]);

  always_ff @(posedge clk) begin
    if (neg_q[NUM_BITS]) begin
      if (qx > WW'(33'h0_8000_0000)) begin
        quot <= 32'sh8000_0000;
      end else begin
        quot <= -$signed(qx[TIME_BITS-1:0]);
      end
    end else begin
      if (qx > WW'(32'h7fff_ffff)) begin
        quot <= 32'sh7fff_ffff;
      end else begin
        quot <= $signed(qx[TIME_BITS-1:0]);
      end
    end
  end

endmodule

// ===== design/sbct_resolve.sv =====
// ----------------------------------------------------------------------------
// sbct_resolve
// combines the axis times into entry time, hit flag and face code
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbct_resolve (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sbct_pkg::side_t                       side,
  input  logic signed [sbct_pkg::TIME_BITS-1:0] tx_in,
  input  logic signed [sbct_pkg::TIME_BITS-1:0] tx_out,
  input  logic signed [sbct_pkg::TIME_BITS-1:0] ty_in,
  input  logic signed [sbct_pkg::TIME_BITS-1:0] ty_out,
  output logic                                  done,
  output logic signed [sbct_pkg::TIME_BITS-1:0] entry_time,
  output logic                                  hit,
  output logic [sbct_pkg::FACE_BITS-1:0]        face_code
);
  import sbct_pkg::*;

  side_t                        side_a;
  logic signed [TIME_BITS-1:0]  tin, tout, tin_next, tout_next;
  logic                         x_later, neg_both, over;
  logic                         x_later_next, neg_both_next, over_next;
  logic signed [TIME_BITS-1:0]  dt_s;
  logic                         miss;
  face_t                        face;

  assign dt_s = $signed({{(TIME_BITS-DT_BITS){1'b0}}, side.dt});

  always_comb begin
    if (side.zy) begin
      x_later_next = !side.zx;
    end else if (side.zx) begin
      x_later_next = 1'b0;
    end else begin
      x_later_next = tx_in > ty_in;
    end
    tin_next = x_later_next ? tx_in : ty_in;
    if (side.zx) begin
      tout_next = ty_out;
    end else if (side.zy) begin
      tout_next = tx_out;
    end else begin
      tout_next = (tx_out < ty_out) ? tx_out : ty_out;
    end
    neg_both_next = (side.zx || tx_in[TIME_BITS-1]) && (side.zy || ty_in[TIME_BITS-1]);
    over_next     = (!side.zx && (tx_in > dt_s)) || (!side.zy && (ty_in > dt_s));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_a <= '0;
    end else begin
      side_a <= side;
    end
  end

  always_ff @(posedge clk) begin
    tin      <= tin_next;
    tout     <= tout_next;
    x_later  <= x_later_next;
    neg_both <= neg_both_next;
    over     <= over_next;
  end

  always_comb begin
    miss = (tin > tout) || neg_both || over;
    if (miss) begin
      face = FACE_NONE;
    end else if (x_later) begin
      face = side_a.gx_pos ? FACE_RIGHT : FACE_LEFT;
    end else if (side_a.zy) begin
      face = FACE_NONE;
    end else begin
      face = side_a.gy_pos ? FACE_TOP : FACE_BOTTOM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      hit       <= 1'b0;
      face_code <= FACE_NONE;
    end else begin
      done      <= side_a.valid;
      hit       <= side_a.valid && !miss;
      face_code <= side_a.valid ? face : FACE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    entry_time <= miss ? $signed({{(TIME_BITS-DT_BITS){1'b0}}, side_a.dt}) : tin;
  end

endmodule

// ===== design/swept_box_collision_time_unit.sv =====
// ----------------------------------------------------------------------------
// swept_box_collision_time_unit
// swept box collision entry time and struck face, fully pipelined
// ----------------------------------------------------------------------------
// One item per clock: busy stays low, so start may be held high every cycle.
// Each item gives one result, strobed by done for one cycle. An item
// passes the front registers, the four dividers, which retire one
// quotient bit per stage, and the resolve registers in that order. The
// receiver cannot stall, so done must be taken as it comes.
`timescale 1ns / 1ps

module swept_box_collision_time_unit #(
  parameter int COORD_BITS     = sbct_pkg::COORD_BITS_DEF,
  parameter int MOVE_FRAC_BITS = sbct_pkg::MOVE_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_BITS-1:0]          obj_left,
  input  logic signed [COORD_BITS-1:0]          obj_top,
  input  logic signed [COORD_BITS-1:0]          obj_right,
  input  logic signed [COORD_BITS-1:0]          obj_bottom,
  input  logic signed [COORD_BITS-1:0]          other_left,
  input  logic signed [COORD_BITS-1:0]          other_top,
  input  logic signed [COORD_BITS-1:0]          other_right,
  input  logic signed [COORD_BITS-1:0]          other_bottom,
  input  logic signed [sbct_pkg::MOVE_BITS-1:0] move_x,
  input  logic signed [sbct_pkg::MOVE_BITS-1:0] move_y,
  input  logic [sbct_pkg::DT_BITS-1:0]          time_limit,
  output logic                                  done,
  output logic signed [sbct_pkg::TIME_BITS-1:0] entry_time,
  output logic                                  hit,
  output logic [sbct_pkg::FACE_BITS-1:0]        face_code
);
  import sbct_pkg::*;
  `include "swept_box_collision_time_unit_macros.svh"

  localparam int NB      = COORD_BITS + 1 + MOVE_FRAC_BITS + TIME_FRAC;
  localparam int DIV_LAT = NB + 1;

  side_t                       side_f;
  side_t                       side_q [1:DIV_LAT];
  logic [NB-1:0]               nx_in, nx_out, ny_in, ny_out;
  logic                        sx_in, sx_out, sy_in, sy_out;
  logic [MOVE_BITS-1:0]        den_x, den_y;
  logic signed [TIME_BITS-1:0] tx_in, tx_out, ty_in, ty_out;

  assign busy = 1'b0;

  sbct_front #(
    .COORD_BITS     (COORD_BITS),
    .MOVE_FRAC_BITS (MOVE_FRAC_BITS),
    .NUM_BITS       (NB)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start && !busy),
    .obj_left     (obj_left),
    .obj_top      (obj_top),
    .obj_right    (obj_right),
    .obj_bottom   (obj_bottom),
    .other_left   (other_left),
    .other_top    (other_top),
    .other_right  (other_right),
    .other_bottom (other_bottom),
    .move_x       (move_x),
    .move_y       (move_y),
    .time_limit   (time_limit),
    .side         (side_f),
    .nx_in        (nx_in),
    .nx_out       (nx_out),
    .ny_in        (ny_in),
    .ny_out       (ny_out),
    .sx_in        (sx_in),
    .sx_out       (sx_out),
    .sy_in        (sy_in),
    .sy_out       (sy_out),
    .den_x        (den_x),
    .den_y        (den_y)
  );

  sbct_div #(.NUM_BITS(NB)) u_div_x_in (
    .clk(clk), .num(nx_in), .neg(sx_in), .den(den_x), .quot(tx_in)
  );
  sbct_div #(.NUM_BITS(NB)) u_div_x_out (
    .clk(clk), .num(nx_out), .neg(sx_out), .den(den_x), .quot(tx_out)
  );
  sbct_div #(.NUM_BITS(NB)) u_div_y_in (
    .clk(clk), .num(ny_in), .neg(sy_in), .den(den_y), .quot(ty_in)
  );
  sbct_div #(.NUM_BITS(NB)) u_div_y_out (
    .clk(clk), .num(ny_out), .neg(sy_out), .den(den_y), .quot(ty_out)
  );

  // side data follows the dividers
  for (genvar i = 1; i <= DIV_LAT; i++) begin : g_side
    side_t prev;
    if (i == 1) begin : g_head
      assign prev = side_f;
    end else begin : g_tail
      assign prev = side_q[i-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        side_q[i] <= '0;
      end else begin
        side_q[i] <= prev;
      end
    end
  end

  sbct_resolve u_resolve (
    .clk        (clk),
    .rst        (rst),
    .side       (side_q[DIV_LAT]),
    .tx_in      (tx_in),
    .tx_out     (tx_out),
    .ty_in      (ty_in),
    .ty_out     (ty_out),
    .done       (done),
    .entry_time (entry_time),
    .hit        (hit),
    .face_code  (face_code)
  );

  `SBCT_ASSERT_IMP(a_hit_needs_done, hit, done, "hit without done")
  `SBCT_ASSERT_IMP(a_miss_no_face, done && !hit, face_code == FACE_NONE, "face on a miss")
  `SBCT_ASSERT_IMP(a_hit_time_nonneg, done && hit, !entry_time[TIME_BITS-1], "negative entry on hit")
  `SBCT_ASSERT_NXT(a_idle_no_done, !u_resolve.side_a.valid, !done, "done without item")

endmodule
